>>> rtl/core/cdad_pkg.sv
// Shared types, constants and calendar tables for the date adder.
// Used by the microcode ROM, sequencer, datapath and top level.
package cdad_pkg;

    localparam int unsigned DAY_W       = 5;
    localparam int unsigned MON_W       = 4;
    localparam int unsigned YEAR_IN_W   = 14;
    localparam int unsigned MOD_W       = 9;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned PC_W        = 3;
    localparam int unsigned ML_W        = 5;
    localparam int unsigned YLEN_W      = 9;
    localparam int unsigned Q_W         = 6;
    localparam int unsigned Q_PROD_W    = 16;
    localparam int unsigned YEAR_SHIFT  = 4;
    localparam int unsigned RECIP_SHIFT = 10;

    localparam logic [YLEN_W-1:0]    DAYS_IN_LEAP_YEAR   = 9'd366;
    localparam logic [YLEN_W-1:0]    DAYS_IN_COMMON_YEAR = 9'd365;
    localparam logic [MOD_W-1:0]     MOD_LAST            = 9'd399;
    localparam logic [MOD_W-1:0]     CENTURY_1           = 9'd100;
    localparam logic [MOD_W-1:0]     CENTURY_2           = 9'd200;
    localparam logic [MOD_W-1:0]     CENTURY_3           = 9'd300;
    // year / 400 is ((year >> 4) * 41) >> 10, exact for 14-bit years
    localparam logic [Q_PROD_W-1:0]  DIV400_RECIP        = 16'd41;
    localparam logic [YEAR_IN_W-1:0] YEAR_DIV            = 14'd400;
    localparam logic [IDX_W-1:0]     LAST_MONTH_IDX      = 4'd11;
    localparam logic [IDX_W-1:0]     FEB_IDX             = 4'd1;
    localparam logic [MON_W-1:0]     MONTH_FIRST         = 4'd1;
    localparam logic [MON_W-1:0]     MONTH_LAST          = 4'd12;
    localparam logic [DAY_W-1:0]     DAY_FIRST           = 5'd1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DIV400,
        OP_SET_M400,
        OP_ADD_MONTH,
        OP_YEAR_STEP,
        OP_CLR_IDX,
        OP_SUB_MONTH,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_MON_LT,
        C_POS_GT_YLEN,
        C_POS_GT_ML
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic mon_lt;
        logic pos_gt_ylen;
        logic pos_gt_ml;
    } status_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } ctrl_t;

    function automatic logic is_leap(input logic [MOD_W-1:0] m400);
        logic div4;
        logic century;
        div4    = (m400[1:0] == 2'b00);
        century = (m400 == CENTURY_1) || (m400 == CENTURY_2) || (m400 == CENTURY_3);
        return div4 && !century;
    endfunction

    function automatic logic [ML_W-1:0] month_len(input logic [IDX_W-1:0] idx,
                                                  input logic leap);
        logic [ML_W-1:0] n;
        case (idx)
            4'd0:    n = 5'd31;
            4'd1:    n = 5'd28;
            4'd2:    n = 5'd31;
            4'd3:    n = 5'd30;
            4'd4:    n = 5'd31;
            4'd5:    n = 5'd30;
            4'd6:    n = 5'd31;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd30;
            4'd9:    n = 5'd31;
            4'd10:   n = 5'd30;
            4'd11:   n = 5'd31;
            default: n = 5'd31;
        endcase
        if (idx == FEB_IDX && leap)
            n = 5'd29;
        return n;
    endfunction

endpackage

>>> rtl/core/cdad_if.sv
// Valid/ready channel interfaces for the date adder request and response.
// Depends on cdad_pkg for field widths.
interface cdad_req_if #(
    parameter int ADD_DAYS_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [cdad_pkg::DAY_W-1:0]     start_day;
    logic [cdad_pkg::MON_W-1:0]     start_month;
    logic [cdad_pkg::YEAR_IN_W-1:0] start_year;
    logic [ADD_DAYS_BITS-1:0]      days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

interface cdad_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cdad_pkg::DAY_W-1:0]     end_day;
    logic [cdad_pkg::MON_W-1:0]     end_month;
    logic [cdad_pkg::YEAR_IN_W-1:0] end_year;

    modport source (output valid, end_day, end_month, end_year, input ready);
    modport sink (input valid, end_day, end_month, end_year, output ready);
endinterface

>>> rtl/core/cdad_urom.sv
// Microcode ROM: one control word per program step of the date adder.
// Depends on cdad_pkg for the control word type.
module cdad_urom (
    input  logic [cdad_pkg::PC_W-1:0] pc,
    output cdad_pkg::uword_t          uword
);
    import cdad_pkg::*;

    localparam logic [PC_W-1:0] PC_DIV      = 3'd0;
    localparam logic [PC_W-1:0] PC_SET_M400 = 3'd1;
    localparam logic [PC_W-1:0] PC_ADD_MON  = 3'd2;
    localparam logic [PC_W-1:0] PC_YEARS    = 3'd3;
    localparam logic [PC_W-1:0] PC_CLR_IDX  = 3'd4;
    localparam logic [PC_W-1:0] PC_SUB_MON  = 3'd5;
    localparam logic [PC_W-1:0] PC_FINISH   = 3'd6;

    always_comb
    begin
        case (pc)
            PC_DIV:      uword = '{op: OP_DIV400,    cond: C_ALWAYS,      target: PC_SET_M400};
            PC_SET_M400: uword = '{op: OP_SET_M400,  cond: C_ALWAYS,      target: PC_ADD_MON};
            PC_ADD_MON:  uword = '{op: OP_ADD_MONTH, cond: C_MON_LT,      target: PC_ADD_MON};
            PC_YEARS:    uword = '{op: OP_YEAR_STEP, cond: C_POS_GT_YLEN, target: PC_YEARS};
            PC_CLR_IDX:  uword = '{op: OP_CLR_IDX,   cond: C_ALWAYS,      target: PC_SUB_MON};
            PC_SUB_MON:  uword = '{op: OP_SUB_MONTH, cond: C_POS_GT_ML,   target: PC_SUB_MON};
            PC_FINISH:   uword = '{op: OP_FINISH,    cond: C_ALWAYS,      target: PC_DIV};
            default:     uword = '{op: OP_FINISH,    cond: C_ALWAYS,      target: PC_DIV};
        endcase
    end

endmodule

>>> rtl/core/cdad_sequencer.sv
// Step counter and jump logic that walks the microcode program.
// Depends on cdad_pkg for control word, status and control types.
module cdad_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      out_free,
    input  cdad_pkg::status_t         status,
    input  cdad_pkg::uword_t          uword,
    output logic [cdad_pkg::PC_W-1:0] pc,
    output cdad_pkg::ctrl_t           ctrl,
    output logic                      busy,
    output logic                      done
);
    import cdad_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic            take;

    always_comb
    begin
        case (uword.cond)
            C_ALWAYS:      take = 1'b1;
            C_MON_LT:      take = status.mon_lt;
            C_POS_GT_YLEN: take = status.pos_gt_ylen;
            C_POS_GT_ML:   take = status.pos_gt_ml;
            default:       take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        ctrl.load = start;
        ctrl.op   = OP_NOP;
        if (busy_reg)
        begin
            if (uword.op == OP_FINISH)
            begin
                if (out_free)
                begin
                    done      = 1'b1;
                    busy_next = 1'b0;
                    pc_next   = uword.target;
                end
            end
            else if (take)
            begin
                ctrl.op = uword.op;
                pc_next = uword.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign pc   = pc_reg;
    assign busy = busy_reg;

endmodule

>>> rtl/core/cdad_datapath.sv
// Datapath: year, day position, month index and year-mod-400 registers.
// Depends on cdad_pkg for control, status types and calendar tables.
module cdad_datapath #(
    parameter int ADD_DAYS_BITS = 16
) (
    input  logic                           clk,
    input  cdad_pkg::ctrl_t                ctrl,
    input  logic [cdad_pkg::DAY_W-1:0]     start_day,
    input  logic [cdad_pkg::MON_W-1:0]     start_month,
    input  logic [cdad_pkg::YEAR_IN_W-1:0] start_year,
    input  logic [ADD_DAYS_BITS-1:0]       days_to_add,
    output cdad_pkg::status_t              status,
    output logic [cdad_pkg::DAY_W-1:0]     end_day,
    output logic [cdad_pkg::MON_W-1:0]     end_month,
    output logic [cdad_pkg::YEAR_IN_W-1:0] end_year
);
    import cdad_pkg::*;

    localparam int POS_W  = ADD_DAYS_BITS + 2;
    localparam int YEAR_W = ADD_DAYS_BITS + 7;

    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [MOD_W-1:0]     m400_reg, m400_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [MON_W-1:0]     mon_reg, mon_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic                 leap;
    logic [ML_W-1:0]      ml;
    logic [YLEN_W-1:0]    ylen;
    logic [Q_PROD_W-1:0]  q_prod;
    logic [YEAR_IN_W-1:0] q_times;
    logic [DAY_W-1:0]     day_fix;
    logic [MON_W-1:0]     mon_fix;

    assign leap    = is_leap(m400_reg);
    assign ml      = month_len(idx_reg, leap);
    assign ylen    = leap ? DAYS_IN_LEAP_YEAR : DAYS_IN_COMMON_YEAR;
    assign q_prod  = Q_PROD_W'(year_reg[YEAR_IN_W-1:YEAR_SHIFT]) * DIV400_RECIP;
    assign q_times = YEAR_IN_W'(q_reg) * YEAR_DIV;
    assign day_fix = (start_day == '0) ? DAY_FIRST : start_day;

    always_comb
    begin
        if (start_month == '0)
            mon_fix = MONTH_FIRST;
        else if (start_month > MONTH_LAST)
            mon_fix = MONTH_LAST;
        else
            mon_fix = start_month;
    end

    assign status.mon_lt      = ({1'b0, idx_reg} + 5'd1) < {1'b0, mon_reg};
    assign status.pos_gt_ylen = pos_reg > POS_W'(ylen);
    assign status.pos_gt_ml   = (idx_reg < LAST_MONTH_IDX) && (pos_reg > POS_W'(ml));

    always_comb
    begin
        year_next = year_reg;
        q_next    = q_reg;
        m400_next = m400_reg;
        pos_next  = pos_reg;
        mon_next  = mon_reg;
        idx_next  = idx_reg;
        if (ctrl.load)
        begin
            year_next = YEAR_W'(start_year);
            pos_next  = POS_W'(day_fix) + POS_W'(days_to_add);
            mon_next  = mon_fix;
            idx_next  = '0;
        end
        else
        begin
            case (ctrl.op)
                OP_DIV400:
                begin
                    q_next = q_prod[Q_PROD_W-1:RECIP_SHIFT];
                end
                OP_SET_M400:
                begin
                    m400_next = MOD_W'(year_reg[YEAR_IN_W-1:0] - q_times);
                    idx_next  = '0;
                end
                OP_ADD_MONTH:
                begin
                    pos_next = pos_reg + POS_W'(ml);
                    idx_next = idx_reg + 1'b1;
                end
                OP_YEAR_STEP:
                begin
                    pos_next  = pos_reg - POS_W'(ylen);
                    year_next = year_reg + 1'b1;
                    m400_next = (m400_reg == MOD_LAST) ? '0 : m400_reg + 1'b1;
                end
                OP_CLR_IDX:
                begin
                    idx_next = '0;
                end
                OP_SUB_MONTH:
                begin
                    pos_next = pos_reg - POS_W'(ml);
                    idx_next = idx_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg <= year_next;
        q_reg    <= q_next;
        m400_reg <= m400_next;
        pos_reg  <= pos_next;
        mon_reg  <= mon_next;
        idx_reg  <= idx_next;
    end

    assign end_day   = pos_reg[DAY_W-1:0];
    assign end_month = MON_W'(idx_reg + 1'b1);
    assign end_year  = year_reg[YEAR_IN_W-1:0];

endmodule

>>> rtl/core/calendar_date_add_days.sv
// Gregorian date plus day count. One request gives one response. The block works on one
// item at a time: it forms the year quotient by 400, sets the year-mod-400 value, adds one
// month length per month before the start month and then takes an exit step to form the
// day-of-year position, steps one whole year at a time with an exit step, clears the month
// index, subtracts up to 11 month lengths with an exit step and posts the result. The
// microcoded sequencer walks the years one per cycle.
// A stalled response holds the sequencer at its last step. A new request is taken as soon
// as the previous result sits in the output register.
// Depends on cdad_pkg, cdad_if, cdad_urom, cdad_sequencer and cdad_datapath.
module calendar_date_add_days #(
    parameter int ADD_DAYS_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    cdad_req_if.sink   req,
    cdad_rsp_if.source rsp
);
    import cdad_pkg::*;

    logic            start;
    logic            out_free;
    logic            busy;
    logic            done;
    logic [PC_W-1:0] pc;
    uword_t          uword;
    ctrl_t           ctrl;
    status_t         status;

    logic [DAY_W-1:0]     dp_day;
    logic [MON_W-1:0]     dp_month;
    logic [YEAR_IN_W-1:0] dp_year;

    logic                 out_valid_reg, out_valid_next;
    logic [DAY_W-1:0]     end_day_reg;
    logic [MON_W-1:0]     end_month_reg;
    logic [YEAR_IN_W-1:0] end_year_reg;

    assign req.ready = !busy;
    assign start     = req.valid && !busy;
    assign out_free  = !out_valid_reg || rsp.ready;

    cdad_urom u_urom (
        .pc    (pc),
        .uword (uword)
    );

    cdad_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .status   (status),
        .uword    (uword),
        .pc       (pc),
        .ctrl     (ctrl),
        .busy     (busy),
        .done     (done)
    );

    cdad_datapath #(
        .ADD_DAYS_BITS (ADD_DAYS_BITS)
    ) u_dp (
        .clk         (clk),
        .ctrl        (ctrl),
        .start_day   (req.start_day),
        .start_month (req.start_month),
        .start_year  (req.start_year),
        .days_to_add (req.days_to_add),
        .status      (status),
        .end_day     (dp_day),
        .end_month   (dp_month),
        .end_year    (dp_year)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            end_day_reg   <= dp_day;
            end_month_reg <= dp_month;
            end_year_reg  <= dp_year;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.end_day   = end_day_reg;
    assign rsp.end_month = end_month_reg;
    assign rsp.end_year  = end_year_reg;

endmodule

>>> rtl/core/cdad_checker.sv
// Port-level checks for calendar_date_add_days, attached by bind.
// Depends on cdad_pkg for field widths.
module cdad_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [cdad_pkg::DAY_W-1:0]     end_day,
    input logic [cdad_pkg::MON_W-1:0]     end_month,
    input logic [cdad_pkg::YEAR_IN_W-1:0] end_year
);
    import cdad_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(end_day)
            && $stable(end_month) && $stable(end_year))
        else $error("response dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in flight");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> end_month >= MONTH_FIRST && end_month <= MONTH_LAST
            && end_day >= DAY_FIRST && end_day <= 5'd31)
        else $error("response date out of range");

    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared without a busy period");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .end_day   (rsp.end_day),
    .end_month (rsp.end_month),
    .end_year  (rsp.end_year)
);

>>> verif/tb_top.sv
// Self-checking bench for calendar_date_add_days: a table of directed dates, then
// random dates and day counts under several idle and stall mixes, checked in order.
// Depends on cdad_pkg, cdad_if and the calendar_date_add_days RTL.
module tb_top;
    import cdad_pkg::*;

    localparam int ADD_BITS     = 16;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int NUM_CASES    = 24;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [DAY_W-1:0]     day;
        logic [MON_W-1:0]     month;
        logic [YEAR_IN_W-1:0] year;
    } date_t;

    typedef struct packed {
        date_t               start;
        logic [ADD_BITS-1:0] add;
        logic                typed;
        date_t               want;
    } date_case_t;

    logic clk;
    logic rst_n;

    cdad_req_if #(.ADD_DAYS_BITS(ADD_BITS)) req_ch ();
    cdad_rsp_if rsp_ch ();

    calendar_date_add_days #(
        .ADD_DAYS_BITS(ADD_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    date_t       pending_dates[$];
    int unsigned send_gap_pct;
    int unsigned stall_pct;
    int          mismatch_count;
    int          quiet_cycles;

    date_case_t date_cases [NUM_CASES] = '{
        '{'{5'd1,  4'd1,  14'd2000},  16'd0,     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{'{5'd31, 4'd12, 14'd1999},  16'd0,     1'b1, '{5'd31, 4'd12, 14'd1999}},
        '{'{5'd31, 4'd12, 14'd1999},  16'd1,     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{'{5'd1,  4'd1,  14'd2001},  16'd364,   1'b1, '{5'd31, 4'd12, 14'd2001}},
        '{'{5'd1,  4'd1,  14'd2000},  16'd365,   1'b1, '{5'd31, 4'd12, 14'd2000}},
        '{'{5'd30, 4'd11, 14'd2023},  16'd31,    1'b1, '{5'd31, 4'd12, 14'd2023}},
        '{'{5'd0,  4'd3,  14'd2023},  16'd0,     1'b1, '{5'd1,  4'd3,  14'd2023}},
        '{'{5'd0,  4'd0,  14'd0},     16'd0,     1'b1, '{5'd1,  4'd1,  14'd0}},
        '{'{5'd31, 4'd2,  14'd2023},  16'd0,     1'b1, '{5'd3,  4'd3,  14'd2023}},
        '{'{5'd29, 4'd2,  14'd2023},  16'd0,     1'b1, '{5'd1,  4'd3,  14'd2023}},
        '{'{5'd31, 4'd4,  14'd2023},  16'd0,     1'b1, '{5'd1,  4'd5,  14'd2023}},
        '{'{5'd10, 4'd0,  14'd2023},  16'd0,     1'b1, '{5'd10, 4'd1,  14'd2023}},
        '{'{5'd15, 4'd15, 14'd2023},  16'd0,     1'b1, '{5'd15, 4'd12, 14'd2023}},
        '{'{5'd29, 4'd2,  14'd0},     16'd0,     1'b1, '{5'd29, 4'd2,  14'd0}},
        '{'{5'd1,  4'd1,  14'd0},     16'd366,   1'b1, '{5'd1,  4'd1,  14'd1}},
        '{'{5'd28, 4'd2,  14'd1900},  16'd1,     1'b1, '{5'd1,  4'd3,  14'd1900}},
        '{'{5'd28, 4'd2,  14'd2000},  16'd1,     1'b1, '{5'd29, 4'd2,  14'd2000}},
        '{'{5'd1,  4'd1,  14'd2100},  16'd59,    1'b1, '{5'd1,  4'd3,  14'd2100}},
        '{'{5'd1,  4'd1,  14'd2400},  16'd59,    1'b1, '{5'd29, 4'd2,  14'd2400}},
        '{'{5'd31, 4'd12, 14'd16383}, 16'd1,     1'b1, '{5'd1,  4'd1,  14'd0}},
        '{'{5'd31, 4'd12, 14'd16383}, 16'hFFFF,  1'b0, '0},
        '{'{5'd31, 4'd15, 14'd16383}, 16'hFFFF,  1'b0, '0},
        '{'{5'd1,  4'd1,  14'd1},     16'hFFFF,  1'b0, '0},
        '{'{5'd17, 4'd6,  14'd9999},  16'd12345, 1'b0, '0}
    };

    function automatic bit leap_year(int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    function automatic int unsigned month_days(int unsigned idx, int unsigned yr);
        if (idx == 1 && leap_year(yr))
            return 29;
        return MONTH_DAYS[idx % 12];
    endfunction

    function automatic int unsigned year_days(int unsigned yr);
        return leap_year(yr) ? int'(DAYS_IN_LEAP_YEAR) : int'(DAYS_IN_COMMON_YEAR);
    endfunction

    function automatic date_t date_after(date_t s, logic [ADD_BITS-1:0] add);
        int unsigned pos;
        int unsigned yr;
        int unsigned mo;
        int unsigned idx;
        int unsigned len;
        date_t       r;
        mo  = (s.month == 0) ? int'(MONTH_FIRST) :
              ((s.month > MONTH_LAST) ? int'(MONTH_LAST) : int'(s.month));
        pos = (s.day == 0) ? int'(DAY_FIRST) : int'(s.day);
        yr  = s.year;
        for (idx = 1; idx < mo; idx++)
            pos += month_days(idx - 1, yr);
        pos += add;
        len = year_days(yr);
        while (pos > len)
        begin
            pos -= len;
            yr++;
            len = year_days(yr);
        end
        idx = 0;
        while (idx < 11 && pos > month_days(idx, yr))
        begin
            pos -= month_days(idx, yr);
            idx++;
        end
        r.day   = 5'(pos);
        r.month = 4'(idx + 1);
        r.year  = 14'(yr);
        return r;
    endfunction

    task automatic send_date(input date_t s, input logic [ADD_BITS-1:0] add, input date_t want);
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.start_day   <= s.day;
        req_ch.start_month <= s.month;
        req_ch.start_year  <= s.year;
        req_ch.days_to_add <= add;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_dates.push_back(want);
    endtask

    task automatic drain_pending();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates.size() != 0);
    endtask

    task automatic run_phase(input int unsigned count, input int unsigned gap,
                             input int unsigned stall);
        date_t       s;
        int unsigned yr;
        int unsigned mo;
        int unsigned add;
        int unsigned kind;
        send_gap_pct = gap;
        stall_pct    = stall;
        repeat (count)
        begin
            kind = $urandom_range(9);
            yr   = $urandom_range(9999, 1);
            mo   = $urandom_range(12, 1);
            case ($urandom_range(3))
                0:       add = $urandom_range(40);
                1:       add = $urandom_range(1500);
                2:       add = $urandom_range(65535);
                default: add = 65535 - $urandom_range(400);
            endcase
            if (kind == 7)
                yr = 100 * $urandom_range(163);
            if (kind == 8)
                yr = 16383 - $urandom_range(3);
            s.year  = 14'(yr);
            s.month = 4'(mo);
            s.day   = 5'($urandom_range(month_days(mo - 1, yr), 1));
            // land exactly on the last day of the start year
            if (kind == 6)
            begin
                s.day   = DAY_FIRST;
                s.month = MONTH_FIRST;
                add     = year_days(yr) - 1;
            end
            if (kind == 9)
                {s.day, s.month, s.year} = 23'($urandom);
            send_date(s, 16'(add), date_after(s, 16'(add)));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        date_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_dates.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected date %0d/%0d/%0d", $time, rsp_ch.end_day,
                             rsp_ch.end_month, rsp_ch.end_year);
                end
                else
                begin
                    want = pending_dates.pop_front();
                    if (rsp_ch.end_day !== want.day || rsp_ch.end_month !== want.month ||
                        rsp_ch.end_year !== want.year)
                    begin
                        mismatch_count++;
                        $display("%0t: date mismatch, expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.day, want.month, want.year, rsp_ch.end_day,
                                 rsp_ch.end_month, rsp_ch.end_year);
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.start_day   = '0;
        req_ch.start_month = '0;
        req_ch.start_year  = '0;
        req_ch.days_to_add = '0;
        send_gap_pct       = 0;
        stall_pct          = 0;
        mismatch_count     = 0;
        quiet_cycles       = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (date_cases[i])
            send_date(date_cases[i].start, date_cases[i].add,
                      date_cases[i].typed ? date_cases[i].want :
                      date_after(date_cases[i].start, date_cases[i].add));
        drain_pending();

        run_phase(258, 0, 0);
        drain_pending();
        run_phase(258, 86, 0);
        drain_pending();
        run_phase(258, 0, 86);
        drain_pending();
        run_phase(258, 28, 28);
        drain_pending();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
